// ===== sv/tilt_direction_classifier_defines.svh =====
// assertion macros for the tilt direction classifier
`ifndef TILT_DIRECTION_CLASSIFIER_DEFINES_SVH
`define TILT_DIRECTION_CLASSIFIER_DEFINES_SVH
// implication checked at every clock edge outside reset
`define TDC_ASSERT_IMP(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define TDC_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== sv/tdc_pkg.sv =====
// package with types, constants and tables for the tilt direction classifier
`timescale 1ns / 1ps
package tdc_pkg;
  localparam int AXIS_W = 17;
  localparam int SQ_W = 35;
  localparam int RAD_W = 26;
  localparam int CX_W = 30;
  localparam int Z_W = 25;
  localparam int ANGLE_MAX = 23040;
  localparam int TAB_N = 24;
  localparam logic [2:0] CMD_STOP = 3'd0;
  localparam logic [2:0] CMD_FORWARD = 3'd1;
  localparam logic [2:0] CMD_BACK = 3'd2;
  localparam logic [2:0] CMD_LEFT = 3'd3;
  localparam logic [2:0] CMD_RIGHT = 3'd4;
  localparam logic [1:0] REG_X_OFFSET = 2'd0;
  localparam logic [1:0] REG_Y_OFFSET = 2'd1;
  localparam logic [1:0] REG_Z_OFFSET = 2'd2;
  localparam logic [1:0] REG_TILT_LIMIT = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] roll_deg;
  } result_t;

  function automatic logic signed [Z_W-1:0] atan_tab(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0: v = 25'sd2949120;   5'd1: v = 25'sd1740967;
      5'd2: v = 25'sd919879;    5'd3: v = 25'sd466945;
      5'd4: v = 25'sd234379;    5'd5: v = 25'sd117304;
      5'd6: v = 25'sd58666;     5'd7: v = 25'sd29335;
      5'd8: v = 25'sd14668;     5'd9: v = 25'sd7334;
      5'd10: v = 25'sd3667;     5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;       5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;       5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;        5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

// ===== sv/tilt_direction_classifier.sv =====
// pipeline: 2 input stages, 26 root stages, CORDIC_STEPS cordic stages, 1 decision stage, then the queue
// throughput: one transaction per cycle, set by the fully pipelined root and cordic
// the pipeline holds only while three results wait, the output stalls and a result arrives
// reset: synchronous active high, clears valids and queue, offsets to 0, tilt limit 5120
`timescale 1ns / 1ps
module tilt_direction_classifier #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // accel_x, accel_y, accel_z
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [39:0] m_axis_tdata,  // command, pitch_deg, roll_deg, pad
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  logic signed [15:0] x_offset, y_offset, z_offset;
  logic [14:0] tilt_limit;
  logic fv, bv, en;
  logic signed [tdc_pkg::AXIS_W-1:0] dx, dy;
  logic [tdc_pkg::RAD_W-1:0] rad_p, rad_r;
  tdc_pkg::result_t res, qd;
  logic [2:0] count;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= '0;
      y_offset <= '0;
      z_offset <= '0;
      tilt_limit <= 15'd5120;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tdc_pkg::REG_X_OFFSET: x_offset <= cfg_data;
        tdc_pkg::REG_Y_OFFSET: y_offset <= cfg_data;
        tdc_pkg::REG_Z_OFFSET: z_offset <= cfg_data;
        tdc_pkg::REG_TILT_LIMIT: tilt_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // stall only when the queue holds three results, the output is not ready and the pipe head would push
  assign en = !(count >= 3'd3 && !m_axis_tready) || !bv;
  assign s_axis_tready = en;

  tdc_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid && en),
    .ax(s_axis_tdata[15:0]), .ay(s_axis_tdata[31:16]), .az(s_axis_tdata[47:32]),
    .x_offset, .y_offset, .z_offset, .en,
    .out_valid(fv), .dx, .dy, .rad_p, .rad_r
  );

  tdc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .in_valid(fv), .dx, .dy, .rad_p, .rad_r, .tilt_limit, .en,
    .out_valid(bv), .result(res)
  );

  tdc_queue #(.DEPTH_W(2)) u_queue (
    .clk, .rst, .in_valid(bv && en), .in_data(res), .count,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(qd)
  );

  assign m_axis_tdata = {5'd0, qd.roll_deg, qd.pitch_deg, qd.command};
endmodule

// ===== sv/tdc_front.sv =====
// front end: offset removal, squares and pipelined square roots
`timescale 1ns / 1ps
module tdc_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] az,
  input  logic signed [15:0] x_offset,
  input  logic signed [15:0] y_offset,
  input  logic signed [15:0] z_offset,
  input  logic en,
  output logic out_valid,
  output logic signed [tdc_pkg::AXIS_W-1:0] dx,
  output logic signed [tdc_pkg::AXIS_W-1:0] dy,
  output logic [tdc_pkg::RAD_W-1:0] rad_p,
  output logic [tdc_pkg::RAD_W-1:0] rad_r
);
  localparam int AW = tdc_pkg::AXIS_W;
  localparam int VW = 2 * tdc_pkg::RAD_W;
  localparam int RW = tdc_pkg::RAD_W;
  localparam int NS = RW;

  // stage 0: corrected axes
  logic v0;
  logic signed [AW-1:0] x0, y0, z0;
  // stage 1: squares
  logic v1;
  logic signed [AW-1:0] x1, y1;
  logic [tdc_pkg::SQ_W-1:0] xx1, yy1, zz1;
  // root pipeline, one result bit per stage
  logic vr [NS+1];
  logic signed [AW-1:0] xr [NS+1], yr [NS+1];
  logic [VW-1:0] remp [NS+1], remr [NS+1];
  logic [RW-1:0] qp [NS+1], qr [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= AW'(ax) - AW'(x_offset);
      y0 <= AW'(ay) - AW'(y_offset);
      z0 <= AW'(az) - AW'(z_offset);
      x1 <= x0;
      y1 <= y0;
      xx1 <= tdc_pkg::SQ_W'(x0 * x0);
      yy1 <= tdc_pkg::SQ_W'(y0 * y0);
      zz1 <= tdc_pkg::SQ_W'(z0 * z0);
    end
  end

  assign vr[0] = v1;
  assign xr[0] = x1;
  assign yr[0] = y1;
  assign remp[0] = VW'({(tdc_pkg::SQ_W + 1)'(yy1) + (tdc_pkg::SQ_W + 1)'(zz1), 16'd0});
  assign remr[0] = VW'({(tdc_pkg::SQ_W + 1)'(xx1) + (tdc_pkg::SQ_W + 1)'(zz1), 16'd0});
  assign qp[0] = '0;
  assign qr[0] = '0;

  for (genvar s = 0; s < NS; s++) begin : g_root
    localparam int B = NS - 1 - s;
    logic [VW-1:0] trp, trr;
    always_comb begin
      trp = VW'({qp[s], 2'b01}) << (2 * B);
      trr = VW'({qr[s], 2'b01}) << (2 * B);
    end
    always_ff @(posedge clk) begin
      if (rst) vr[s+1] <= 1'b0;
      else if (en) vr[s+1] <= vr[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xr[s+1] <= xr[s];
        yr[s+1] <= yr[s];
        if (remp[s] >= trp) begin
          remp[s+1] <= remp[s] - trp;
          qp[s+1] <= {qp[s][RW-2:0], 1'b1};
        end else begin
          remp[s+1] <= remp[s];
          qp[s+1] <= {qp[s][RW-2:0], 1'b0};
        end
        if (remr[s] >= trr) begin
          remr[s+1] <= remr[s] - trr;
          qr[s+1] <= {qr[s][RW-2:0], 1'b1};
        end else begin
          remr[s+1] <= remr[s];
          qr[s+1] <= {qr[s][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vr[NS];
  assign dx = xr[NS];
  assign dy = yr[NS];
  assign rad_p = qp[NS];
  assign rad_r = qr[NS];
endmodule

// ===== sv/tdc_back.sv =====
// back end: twin vectoring cordic pipelines and direction decision
`timescale 1ns / 1ps
module tdc_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [tdc_pkg::AXIS_W-1:0] dx,
  input  logic signed [tdc_pkg::AXIS_W-1:0] dy,
  input  logic [tdc_pkg::RAD_W-1:0] rad_p,
  input  logic [tdc_pkg::RAD_W-1:0] rad_r,
  input  logic [14:0] tilt_limit,
  input  logic en,
  output logic out_valid,
  output tdc_pkg::result_t result
);
  localparam int CW = tdc_pkg::CX_W;
  localparam int ZW = tdc_pkg::Z_W;
  localparam int N = CORDIC_STEPS;

  logic vc [N+1];
  logic zc [N+1];
  logic signed [CW-1:0] xp [N+1], yp [N+1], xq [N+1], yq [N+1];
  logic signed [ZW-1:0] zp [N+1], zq [N+1];

  assign vc[0] = in_valid;
  assign zc[0] = (dx == '0) && (dy == '0) && (rad_p == '0) && (rad_r == '0);
  assign xp[0] = CW'(rad_p);
  assign yp[0] = CW'($signed({dx, 8'd0}));
  assign xq[0] = CW'(rad_r);
  assign yq[0] = CW'($signed({dy, 8'd0}));
  assign zp[0] = '0;
  assign zq[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [ZW-1:0] A = tdc_pkg::atan_tab(5'(i));
    always_ff @(posedge clk) begin
      if (rst) vc[i+1] <= 1'b0;
      else if (en) vc[i+1] <= vc[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        zc[i+1] <= zc[i];
        if (yp[i] > 0) begin
          xp[i+1] <= xp[i] + (yp[i] >>> i);
          yp[i+1] <= yp[i] - (xp[i] >>> i);
          zp[i+1] <= zp[i] + A;
        end else begin
          xp[i+1] <= xp[i] - (yp[i] >>> i);
          yp[i+1] <= yp[i] + (xp[i] >>> i);
          zp[i+1] <= zp[i] - A;
        end
        if (yq[i] > 0) begin
          xq[i+1] <= xq[i] + (yq[i] >>> i);
          yq[i+1] <= yq[i] - (xq[i] >>> i);
          zq[i+1] <= zq[i] + A;
        end else begin
          xq[i+1] <= xq[i] - (yq[i] >>> i);
          yq[i+1] <= yq[i] + (xq[i] >>> i);
          zq[i+1] <= zq[i] - A;
        end
      end
    end
  end

  // round, negate, saturate, and zero for an all-zero input
  logic signed [ZW-1:0] rp, rr;
  logic signed [16:0] p, r;
  always_comb begin
    rp = -((zp[N] + ZW'(128)) >>> 8);
    rr = -((zq[N] + ZW'(128)) >>> 8);
    if (zc[N]) p = '0;
    else if (rp > ZW'(tdc_pkg::ANGLE_MAX)) p = 17'(tdc_pkg::ANGLE_MAX);
    else if (rp < -ZW'(tdc_pkg::ANGLE_MAX)) p = -17'(tdc_pkg::ANGLE_MAX);
    else p = 17'(rp);
    if (zc[N]) r = '0;
    else if (rr > ZW'(tdc_pkg::ANGLE_MAX)) r = 17'(tdc_pkg::ANGLE_MAX);
    else if (rr < -ZW'(tdc_pkg::ANGLE_MAX)) r = -17'(tdc_pkg::ANGLE_MAX);
    else r = 17'(rr);
  end

  logic vd;
  logic zd;
  logic signed [16:0] pd, rd, lim;
  assign lim = 17'({2'b00, tilt_limit});
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (en) vd <= vc[N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pd <= p;
      rd <= r;
      zd <= zc[N];
    end
  end

  always_comb begin
    result.pitch_deg = 16'(pd);
    result.roll_deg = 16'(rd);
    if (zd) result.command = tdc_pkg::CMD_STOP;
    else if (pd > -lim && pd < lim && rd > -lim && rd < lim)
      result.command = tdc_pkg::CMD_STOP;
    else if (pd > 0 && rd > 0)
      result.command = (pd > rd) ? tdc_pkg::CMD_BACK : tdc_pkg::CMD_LEFT;
    else if (pd < 0 && rd < 0)
      result.command = (pd > rd) ? tdc_pkg::CMD_RIGHT : tdc_pkg::CMD_FORWARD;
    else if (pd > 0 && rd < 0)
      result.command = (pd > -rd) ? tdc_pkg::CMD_BACK : tdc_pkg::CMD_RIGHT;
    else
      result.command = (-pd > rd) ? tdc_pkg::CMD_FORWARD : tdc_pkg::CMD_LEFT;
  end
  assign out_valid = vd;
endmodule

// ===== sv/tdc_queue.sv =====
// output queue that lets the pipeline run while results wait
`timescale 1ns / 1ps
`include "tilt_direction_classifier_defines.svh"
module tdc_queue #(
  parameter int DEPTH_W = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  tdc_pkg::result_t in_data,
  output logic [DEPTH_W:0] count,
  output logic out_valid,
  input  logic out_ready,
  output tdc_pkg::result_t out_data
);
  localparam int DEPTH = 1 << DEPTH_W;
  tdc_pkg::result_t mem [DEPTH];
  logic [DEPTH_W-1:0] wr_ptr, rd_ptr;
  logic push, pop;

  assign push = in_valid;
  assign pop = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (DEPTH_W + 1)'(push) - (DEPTH_W + 1)'(pop);
    end
  end
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  `TDC_ASSERT_IMP(a_no_overflow, push && !pop, count < (DEPTH_W + 1)'(DEPTH), "queue overflow")
  `TDC_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count lost push")
  `TDC_ASSERT_IMP(a_ptr_gap, 1'b1, DEPTH_W'(wr_ptr - rd_ptr) == DEPTH_W'(count), "pointer skew")
endmodule

// ===== tb/sv/tilt_direction_classifier_checker.sv =====
// checker: predicts pitch, roll and command per sample and compares with the output stream
`timescale 1ns / 1ps
module tilt_direction_classifier_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int errors,
  output int pending
);
  logic signed [15:0] off_x, off_y, off_z;
  logic [14:0] limit;
  tdc_pkg::result_t expected_q[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint tilt_angle(longint num, longint a, longint b);
    longint cx, cy, cz, xs, ys, q;
    cx = int_sqrt((a * a + b * b) <<< 16);
    cy = num * 256;
    cz = 0;
    if (cx == 0 && cy == 0) return 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = floor_shift(cx, i);
      ys = floor_shift(cy, i);
      if (cy > 0) begin
        cx = cx + ys;
        cy = cy - xs;
        cz = cz + longint'(tdc_pkg::atan_tab(5'(i)));
      end else begin
        cx = cx - ys;
        cy = cy + xs;
        cz = cz - longint'(tdc_pkg::atan_tab(5'(i)));
      end
    end
    q = -floor_shift(cz + 128, 8);
    if (q > tdc_pkg::ANGLE_MAX) q = tdc_pkg::ANGLE_MAX;
    if (q < -tdc_pkg::ANGLE_MAX) q = -tdc_pkg::ANGLE_MAX;
    return q;
  endfunction

  function automatic tdc_pkg::result_t classify(logic [47:0] d);
    longint dx, dy, dz, p, r, lim;
    tdc_pkg::result_t res;
    dx = longint'($signed(d[15:0])) - longint'(off_x);
    dy = longint'($signed(d[31:16])) - longint'(off_y);
    dz = longint'($signed(d[47:32])) - longint'(off_z);
    lim = longint'(limit);
    if (dx == 0 && dy == 0 && dz == 0) begin
      p = 0;
      r = 0;
      res.command = tdc_pkg::CMD_STOP;
    end else begin
      p = tilt_angle(dx, dy, dz);
      r = tilt_angle(dy, dx, dz);
      if (p > -lim && p < lim && r > -lim && r < lim) res.command = tdc_pkg::CMD_STOP;
      else if (p > 0 && r > 0)
        res.command = (p > r) ? tdc_pkg::CMD_BACK : tdc_pkg::CMD_LEFT;
      else if (p < 0 && r < 0)
        res.command = (p > r) ? tdc_pkg::CMD_RIGHT : tdc_pkg::CMD_FORWARD;
      else if (p > 0 && r < 0)
        res.command = (p > -r) ? tdc_pkg::CMD_BACK : tdc_pkg::CMD_RIGHT;
      else res.command = (-p > r) ? tdc_pkg::CMD_FORWARD : tdc_pkg::CMD_LEFT;
    end
    res.pitch_deg = 16'(p);
    res.roll_deg = 16'(r);
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    tdc_pkg::result_t want;
    if (rst) begin
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
      limit <= 15'd5120;
      errors <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(classify(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected output transaction", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[2:0] != want.command)
            report("command", m_axis_tdata[2:0], want.command);
          if ($signed(m_axis_tdata[18:3]) != want.pitch_deg)
            report("pitch", $signed(m_axis_tdata[18:3]), want.pitch_deg);
          if ($signed(m_axis_tdata[34:19]) != want.roll_deg)
            report("roll", $signed(m_axis_tdata[34:19]), want.roll_deg);
        end
      end
      pending <= expected_q.size();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tdc_pkg::REG_X_OFFSET: off_x <= cfg_data;
          tdc_pkg::REG_Y_OFFSET: off_y <= cfg_data;
          tdc_pkg::REG_Z_OFFSET: off_z <= cfg_data;
          tdc_pkg::REG_TILT_LIMIT: limit <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/sv/tilt_direction_classifier_tb.sv =====
// testbench top: drives samples, offset and tilt limit settings and receiver stalls, gives the verdict
`timescale 1ns / 1ps
module tilt_direction_classifier_tb;
  localparam int DRAIN = 60;
  localparam longint LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int errors;
  int pending;
  longint cycles = 0;
  bit stall_enable = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tilt_direction_classifier u_dut (.*);
  tilt_direction_classifier_checker u_chk (.*);

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int n;
    forever begin
      @(posedge clk);
      m_axis_tready <= 1'b1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk);
      if (stall_enable) begin
        m_axis_tready <= 1'b0;
        n = gap_len();
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az, bit gaps);
    int n;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {az, ay, ax};
    do @(posedge clk); while (!s_axis_tready);
    if (gaps) begin
      n = gap_len();
      if (n > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  task automatic finish_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    finish_sending();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    logic [15:0] ax, ay, az;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          ax = 16'($urandom());
          ay = 16'($urandom());
          az = 16'($urandom());
        end
        1: begin
          ax = 16'($signed($urandom_range(0, 4000)) - 2000);
          ay = 16'($signed($urandom_range(0, 4000)) - 2000);
          az = 16'($signed($urandom_range(0, 40000)) - 20000);
        end
        2: begin
          ax = 16'($signed($urandom_range(0, 20)) - 10);
          ay = 16'($signed($urandom_range(0, 20)) - 10);
          az = 16'($signed($urandom_range(0, 20)) - 10);
        end
        default: begin
          ax = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
          ay = 16'($urandom());
          az = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom());
        end
      endcase
      send_sample(ax, ay, az, i % 200 < 150);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: level, axis extremes, zero denominators, quadrants
    send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h7fff, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h8000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h0000, 16'h7fff, 16'h0000, 1'b0);
    send_sample(16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h7fff, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h8000, 1'b0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_sample(16'd8000, 16'd4000, 16'd16384, 1'b1);
    send_sample(16'd4000, 16'd8000, 16'd16384, 1'b1);
    send_sample(-16'sd8000, -16'sd4000, 16'd16384, 1'b1);
    send_sample(-16'sd4000, -16'sd8000, 16'd16384, 1'b1);
    send_sample(16'd8000, -16'sd4000, 16'd16384, 1'b1);
    send_sample(16'd4000, -16'sd8000, 16'd16384, 1'b1);
    send_sample(-16'sd8000, 16'd4000, 16'd16384, 1'b1);
    send_sample(16'd0, 16'd8000, 16'd16384, 1'b1);
    send_sample(16'd8000, 16'd0, 16'd16384, 1'b1);
    send_sample(16'd1, 16'd0, 16'd0, 1'b1);
    send_sample(16'hffff, 16'h0001, 16'h0000, 1'b1);
    wait_idle();

    // zero dead zone and extreme offsets
    write_reg(tdc_pkg::REG_TILT_LIMIT, 16'd0);
    write_reg(tdc_pkg::REG_X_OFFSET, 16'h7fff);
    write_reg(tdc_pkg::REG_Y_OFFSET, 16'h8000);
    write_reg(tdc_pkg::REG_Z_OFFSET, 16'h7fff);
    send_sample(16'h7fff, 16'h8000, 16'h7fff, 1'b0);
    send_sample(16'h8000, 16'h7fff, 16'h8000, 1'b0);
    random_phase(200);
    wait_idle();

    // dead zone at the angle limit, upper bit of wide value dropped
    write_reg(tdc_pkg::REG_TILT_LIMIT, 16'hda00);
    write_reg(tdc_pkg::REG_X_OFFSET, 16'h8000);
    write_reg(tdc_pkg::REG_Y_OFFSET, 16'h7fff);
    write_reg(tdc_pkg::REG_Z_OFFSET, 16'h8000);
    random_phase(200);
    wait_idle();

    write_reg(tdc_pkg::REG_TILT_LIMIT, 16'h7fff);
    random_phase(100);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(tdc_pkg::REG_X_OFFSET,
                $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 60)));
      write_reg(tdc_pkg::REG_Y_OFFSET, 16'($signed($urandom_range(0, 600)) - 300));
      write_reg(tdc_pkg::REG_Z_OFFSET, 16'($signed($urandom_range(0, 600)) - 300));
      write_reg(tdc_pkg::REG_TILT_LIMIT, 16'($urandom_range(0, 23040)));
      if (ph == 3) stall_enable = 1'b0;
      random_phase(150);
      wait_idle();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/tdc_pkg.sv
sv/tdc_front.sv
sv/tdc_back.sv
sv/tdc_queue.sv
sv/tilt_direction_classifier.sv
tb/sv/tilt_direction_classifier_checker.sv
tb/sv/tilt_direction_classifier_tb.sv
